/* hw/rtl/gbu_pkg.sv */
// shared constants, types and command and status structs of the gmm background pixel update
package gbu_pkg;

   localparam int PIXEL_COUNT = 131072;
   localparam int MAX_KEPT    = 4;
   localparam int SLOTS       = MAX_KEPT + 1;
   localparam int PIX_W       = 17;
   localparam int IDX_W       = $clog2(PIXEL_COUNT);
   localparam int CNT_W       = 3;
   localparam int IX_W        = $clog2(SLOTS);

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // serial divider geometry
   localparam int DIV_NUM_W = 35;
   localparam int DIV_DEN_W = 21;
   localparam int DIV_Q_W   = 17;
   localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

   typedef enum logic [2:0] {
      CSR_LEARNING_RATE,
      CSR_COMPLEXITY_PRIOR,
      CSR_INITIAL_SIGMA,
      CSR_FOREGROUND_FRACTION,
      CSR_SIGMA_FLOOR,
      CSR_SIGMA_CEILING,
      CSR_MATCH_SCALE,
      CSR_BG_SCALE
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_SEED   = 1'b0,
      REQ_UPDATE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [16:0] weight;
      logic [12:0] sigma;
      logic [47:0] means;
   } slot_type;

   typedef struct packed {
      logic [17:0] weight;
      logic [12:0] sigma;
      logic [47:0] means;
   } work_type;

   typedef struct packed {
      slot_type [SLOTS-1:0] slot;
      logic [CNT_W-1:0]     count;
   } row_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_COMP,
      ST_MUL2,
      ST_EVAL,
      ST_RHO,
      ST_AMUL,
      ST_ASUM,
      ST_KEEP,
      ST_NORM_CHK,
      ST_NORM_WAIT,
      ST_BUB,
      ST_BUB_STEP,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_req;
      logic seed_wr;
      logic mem_rd;
      logic load_row;
      logic mul1;
      logic mul2;
      logic eval;
      logic rho_cap;
      logic amul;
      logic asum;
      logic keep;
      logic add_new;
      logic norm_start;
      logic norm_wr;
      logic bub_load;
      logic bub_step;
      logic mem_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic seed;
      logic out_range;
      logic comp_end;
      logic hit;
      logic rho_div;
      logic div_done;
      logic matched;
      logic norm_skip;
      logic norm_end;
      logic bub_skip;
      logic bub_move;
      logic rsp_free;
   } status_type;

endpackage

/* hw/rtl/gbu_div.sv */
// restoring divider, one quotient bit per cycle
module gbu_div import gbu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 done,
   output logic [DIV_Q_W-1:0]   quo
);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   lo_ff, lo_in;
   logic [DIV_Q_W-1:0]   q_ff, q_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, lo_ff[DIV_Q_W-1]};
      if (start) begin
         // quotient is known to fit, so the high part is already below the divisor
         rem_in  = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
         lo_in   = num[DIV_Q_W-1:0];
         den_in  = den;
         cnt_in  = DIV_CNT_W'(DIV_Q_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
            q_in   = {q_ff[DIV_Q_W-2:0], 1'b0};
         end
         lo_in  = {lo_ff[DIV_Q_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

/* hw/rtl/gbu_datapath.sv */
// model memory, component arithmetic, working arrays, registers and result stage
module gbu_datapath import gbu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data,
   input  logic             req_type,
   input  logic [PIX_W-1:0] req_pixel_index,
   input  logic [7:0]       req_chan_a,
   input  logic [7:0]       req_chan_b,
   input  logic [7:0]       req_chan_c,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [PIX_W-1:0] rsp_out_index,
   output logic             rsp_is_background,
   output logic [2:0]       rsp_component_total
);

   // configuration
   logic [15:0] lr_ff, ct_ff, cf_ff;
   logic [12:0] isig_ff, sfloor_ff, sceil_ff;
   logic [4:0]  mscale_ff, bscale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff     <= 16'd131;
         ct_ff     <= 16'd3277;
         isig_ff   <= 13'd2816;
         cf_ff     <= 16'd6554;
         sfloor_ff <= 13'd1280;
         sceil_ff  <= 13'd5120;
         mscale_ff <= 5'd9;
         bscale_ff <= 5'd16;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEARNING_RATE:       lr_ff     <= csr_data;
            CSR_COMPLEXITY_PRIOR:    ct_ff     <= csr_data;
            CSR_INITIAL_SIGMA:       isig_ff   <= csr_data[12:0];
            CSR_FOREGROUND_FRACTION: cf_ff     <= csr_data;
            CSR_SIGMA_FLOOR:         sfloor_ff <= csr_data[12:0];
            CSR_SIGMA_CEILING:       sceil_ff  <= csr_data[12:0];
            CSR_MATCH_SCALE:         mscale_ff <= csr_data[4:0];
            CSR_BG_SCALE:            bscale_ff <= csr_data[4:0];
         endcase
      end
   end

   // captured transaction
   logic             kind_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [47:0]      xpk_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_type;
         pix_ff  <= req_pixel_index;
         xpk_ff  <= {req_chan_c, 8'h00, req_chan_b, 8'h00, req_chan_a, 8'h00};
      end
   end

   // working state
   slot_type         src_ff [SLOTS];
   work_type         dst_ff [SLOTS];
   logic [CNT_W-1:0] n_ff, i_ff, j_ff, k_ff, b_ff, touched_ff;
   logic             tvld_ff, matched_ff, bg_ff, hit_ff, rho_div_ff;
   logic [20:0]      sum_ff;
   logic [31:0]      decay_ff;
   slot_type         cur;
   logic [16:0]      cw_ff;
   logic [12:0]      cs_ff;
   logic [47:0]      cm_ff;
   logic signed [16:0] sd_ff [3];
   logic [31:0]      sq_ff [3];
   logic [25:0]      s2_ff;
   logic [32:0]      tw_ff;
   logic [33:0]      dist_ff;
   logic [30:0]      ms2_ff, bs2_ff;
   logic [33:0]      tsum_ff;
   logic signed [35:0] dd_ff;
   logic [16:0]      rho_ff;
   logic signed [34:0] pm_ff [3];
   logic signed [53:0] ps_ff;
   work_type         tmp_ff;

   // memory
   row_type          row_mem [PIXEL_COUNT];
   row_type          rd_ff;
   row_type          seed_row, upd_row, wr_row;
   logic             mem_we;

   always_comb begin
      seed_row = '0;
      seed_row.slot[0].weight = ONE_Q16;
      seed_row.slot[0].sigma  = isig_ff;
      seed_row.slot[0].means  = xpk_ff;
      seed_row.count          = CNT_W'(1);
      upd_row.count = j_ff;
      for (int s = 0; s < SLOTS; s++) begin
         upd_row.slot[s].weight = dst_ff[s].weight[16:0];
         upd_row.slot[s].sigma  = dst_ff[s].sigma;
         upd_row.slot[s].means  = dst_ff[s].means;
      end
      wr_row = cmd.seed_wr ? seed_row : upd_row;
      mem_we = cmd.seed_wr | cmd.mem_wr;
   end

   always_ff @(posedge clock) begin
      if (mem_we) row_mem[pix_ff[IDX_W-1:0]] <= wr_row;
      if (cmd.mem_rd) rd_ff <= row_mem[pix_ff[IDX_W-1:0]];
   end

   // divider
   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_Q_W-1:0]   div_q;

   // component evaluation
   logic        hit_c, bg_c, need_c;
   logic [16:0] bg_lim;
   logic [33:0] tw_full;
   logic [15:0] ad [3];
   logic signed [16:0] sd_c [3];

   // working array read and write ports
   logic [CNT_W-1:0] b_m1, rd_idx, wr_idx;
   work_type         dst_rd, wr_data;
   logic             wr_en;

   // adaptation results
   logic signed [36:0] mv;
   logic [20:0]        mh;
   logic [47:0]        nm;
   logic signed [54:0] st, sr;
   logic [30:0]        sv;
   logic [12:0]        ns;
   logic [33:0]        lw_full;
   logic [17:0]        lw;
   logic               keep_c;

   assign cur    = src_ff[i_ff[IX_W-1:0]];
   assign bg_lim = ONE_Q16 - {1'b0, cf_ff};
   assign hit_c  = !matched_ff && (dist_ff < {3'b0, ms2_ff});
   assign bg_c   = !matched_ff && (sum_ff < 21'(bg_lim)) && (dist_ff < {3'b0, bs2_ff});
   assign need_c = cw_ff > {1'b0, lr_ff};
   assign tw_full = 34'(cur.weight) * 34'(ONE_Q16 - {1'b0, lr_ff});

   assign b_m1   = (b_ff == '0) ? '0 : b_ff - 1'b1;
   assign rd_idx = cmd.bub_load ? touched_ff :
                   (cmd.norm_start | cmd.norm_wr) ? k_ff : b_m1;
   assign dst_rd = dst_ff[rd_idx[IX_W-1:0]];

   assign div_start = (cmd.eval && hit_c && need_c) || cmd.norm_start;
   assign div_num   = cmd.norm_start ?
                      35'({dst_rd.weight, 16'h0}) + 35'(sum_ff[20:1]) :
                      35'({lr_ff, 16'h0});
   assign div_den   = cmd.norm_start ? sum_ff : 21'(cw_ff);

   gbu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sd_c[c] = $signed({1'b0, xpk_ff[16*c +: 16]}) - $signed({1'b0, cur.means[16*c +: 16]});
         ad[c]   = (xpk_ff[16*c +: 16] > cur.means[16*c +: 16]) ?
                   xpk_ff[16*c +: 16] - cur.means[16*c +: 16] :
                   cur.means[16*c +: 16] - xpk_ff[16*c +: 16];
      end
   end

   // mean and sigma adaptation
   always_comb begin
      nm = '0;
      mv = '0;
      mh = '0;
      for (int c = 0; c < 3; c++) begin
         mv = $signed({5'b0, cm_ff[16*c +: 16], 16'h0}) + 37'(pm_ff[c]) + 37'sd32768;
         if (mv < 0) mh = '0;
         else mh = mv[36:16];
         nm[16*c +: 16] = (mh > 21'd65535) ? 16'hFFFF : mh[15:0];
      end
      st = $signed({18'b0, cs_ff, 24'h0}) + 55'(ps_ff);
      sr = st + 55'sd8388608;
      if (st > 0) sv = sr[54:24];
      else sv = '0;
      if (sv > 31'(sceil_ff)) sv = 31'(sceil_ff);
      if (sv < 31'(sfloor_ff)) sv = 31'(sfloor_ff);
      ns = sv[12:0];
   end

   assign keep_c  = tsum_ff >= 34'({decay_ff, 1'b0});
   assign lw_full = tsum_ff - 34'(decay_ff) + 34'd32768;
   assign lw      = lw_full[33:16];

   // working array write port
   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = j_ff;
      wr_data = dst_rd;
      if (cmd.keep) begin
         wr_en   = keep_c;
         wr_data = '{weight: lw, sigma: cs_ff, means: cm_ff};
      end else if (cmd.add_new) begin
         wr_en   = 1'b1;
         wr_data = '{weight: 18'(lr_ff), sigma: isig_ff, means: xpk_ff};
      end else if (cmd.norm_wr) begin
         wr_en   = 1'b1;
         wr_idx  = k_ff;
         wr_data = '{weight: 18'(div_q), sigma: dst_rd.sigma, means: dst_rd.means};
      end else if (cmd.bub_step) begin
         wr_en  = 1'b1;
         wr_idx = b_ff;
         if (!status.bub_move) wr_data = tmp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) dst_ff[wr_idx[IX_W-1:0]] <= wr_data;

      if (cmd.load_row) begin
         for (int s = 0; s < SLOTS; s++) src_ff[s] <= rd_ff.slot[s];
         n_ff       <= (rd_ff.count > CNT_W'(MAX_KEPT)) ? CNT_W'(MAX_KEPT) : rd_ff.count;
         decay_ff   <= lr_ff * ct_ff;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
         sum_ff     <= '0;
         matched_ff <= 1'b0;
         bg_ff      <= 1'b0;
         tvld_ff    <= 1'b0;
      end

      if (cmd.mul1) begin
         for (int c = 0; c < 3; c++) begin
            sd_ff[c] <= sd_c[c];
            sq_ff[c] <= ad[c] * ad[c];
         end
         s2_ff <= 26'(cur.sigma) * 26'(cur.sigma);
         tw_ff <= tw_full[32:0];
         cw_ff <= cur.weight;
         cs_ff <= cur.sigma;
         cm_ff <= cur.means;
      end

      if (cmd.mul2) begin
         dist_ff <= 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
         ms2_ff  <= 31'(mscale_ff) * 31'(s2_ff);
         bs2_ff  <= 31'(bscale_ff) * 31'(s2_ff);
      end

      if (cmd.eval) begin
         hit_ff     <= hit_c;
         rho_div_ff <= hit_c & need_c;
         rho_ff     <= ONE_Q16;
         if (hit_c) matched_ff <= 1'b1;
         if (bg_c) bg_ff <= 1'b1;
         tsum_ff <= 34'(tw_ff) + (hit_c ? 34'({lr_ff, 16'h0}) : 34'd0);
         dd_ff   <= $signed({2'b0, dist_ff}) - $signed({15'b0, cs_ff, 8'h0});
      end

      if (cmd.rho_cap) rho_ff <= div_q;

      if (cmd.amul) begin
         for (int c = 0; c < 3; c++) pm_ff[c] <= $signed({1'b0, rho_ff}) * sd_ff[c];
         ps_ff <= $signed({1'b0, rho_ff}) * dd_ff;
      end

      if (cmd.asum) begin
         cm_ff <= nm;
         cs_ff <= ns;
      end

      if (cmd.keep) begin
         i_ff <= i_ff + 1'b1;
         if (keep_c) begin
            sum_ff <= sum_ff + 21'(lw);
            j_ff   <= j_ff + 1'b1;
            if (hit_ff) begin
               touched_ff <= j_ff;
               tvld_ff    <= 1'b1;
            end
         end
      end

      if (cmd.add_new) begin
         sum_ff     <= sum_ff + 21'(lr_ff);
         touched_ff <= j_ff;
         tvld_ff    <= 1'b1;
         j_ff       <= j_ff + 1'b1;
      end

      if (cmd.norm_wr) k_ff <= k_ff + 1'b1;

      if (cmd.bub_load) begin
         tmp_ff <= dst_rd;
         b_ff   <= touched_ff;
      end
      if (cmd.bub_step && status.bub_move) b_ff <= b_m1;
   end

   // result stage
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_index_ff;
   logic             rsp_bg_ff;
   logic [2:0]       rsp_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_index_ff <= pix_ff;
         if (status.out_range) begin
            rsp_bg_ff    <= 1'b0;
            rsp_total_ff <= 3'd0;
         end else if (status.seed) begin
            rsp_bg_ff    <= 1'b1;
            rsp_total_ff <= 3'd1;
         end else begin
            rsp_bg_ff    <= bg_ff;
            rsp_total_ff <= j_ff;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_index       = rsp_index_ff;
   assign rsp_is_background   = rsp_bg_ff;
   assign rsp_component_total = rsp_total_ff;

   always_comb begin
      status.seed      = req_kind_type'(kind_ff) == REQ_SEED;
      status.out_range = 32'(pix_ff) >= 32'(PIXEL_COUNT);
      status.comp_end  = i_ff == n_ff;
      status.hit       = hit_ff;
      status.rho_div   = rho_div_ff;
      status.div_done  = div_done;
      status.matched   = matched_ff;
      status.norm_skip = sum_ff == '0;
      status.norm_end  = k_ff == j_ff;
      status.bub_skip  = !tvld_ff || (touched_ff == '0);
      status.bub_move  = (b_ff != '0) && (tmp_ff.weight > dst_rd.weight);
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

endmodule

/* hw/rtl/gbu_ctrl.sv */
// sequencing state machine for the pixel update
module gbu_ctrl import gbu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.out_range) begin
               state_in = ST_FINISH;
            end else if (status.seed) begin
               cmd.seed_wr = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load_row = 1'b1;
            state_in     = ST_COMP;
         end
         ST_COMP: begin
            if (status.comp_end) begin
               // nothing matched: the sample opens a component of its own
               cmd.add_new = !status.matched;
               state_in    = ST_NORM_CHK;
            end else begin
               cmd.mul1 = 1'b1;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_RHO;
         end
         ST_RHO: begin
            if (!status.hit) begin
               state_in = ST_KEEP;
            end else if (!status.rho_div) begin
               state_in = ST_AMUL;
            end else if (status.div_done) begin
               cmd.rho_cap = 1'b1;
               state_in    = ST_AMUL;
            end
         end
         ST_AMUL: begin
            cmd.amul = 1'b1;
            state_in = ST_ASUM;
         end
         ST_ASUM: begin
            cmd.asum = 1'b1;
            state_in = ST_KEEP;
         end
         ST_KEEP: begin
            cmd.keep = 1'b1;
            state_in = ST_COMP;
         end
         ST_NORM_CHK: begin
            if (status.norm_skip || status.norm_end) begin
               state_in = ST_BUB;
            end else begin
               cmd.norm_start = 1'b1;
               state_in       = ST_NORM_WAIT;
            end
         end
         ST_NORM_WAIT: begin
            if (status.div_done) begin
               cmd.norm_wr = 1'b1;
               state_in    = ST_NORM_CHK;
            end
         end
         ST_BUB: begin
            if (status.bub_skip) begin
               state_in = ST_WRITE;
            end else begin
               cmd.bub_load = 1'b1;
               state_in     = ST_BUB_STEP;
            end
         end
         ST_BUB_STEP: begin
            cmd.bub_step = 1'b1;
            if (!status.bub_move) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.mem_wr = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

endmodule

/* hw/rtl/gmm_background_pixel_update.sv */
// top level of the per-pixel gaussian mixture background update
//
//   port group   direction   handshake           carries
//   req_*        in          req_valid/stall     seed or update sample for one pixel
//   rsp_*        out         rsp_valid/stall     pixel index, background flag, component count
//   csr_*        in          csr_wr_en           register index and write data
//
// one transaction at a time: a seed or out-of-range request goes from decode straight
// to the result; an update runs the component loop, renormalizes each kept component
// and moves the touched one forward before the row is written back. the 17-step serial
// divider is used for the adaptation rate and for each normalization. reset is
// synchronous; model memory contents are undefined until a pixel is seeded. a
// finished result waits in the output register under rsp_stall while the next
// request is already taken.
module gmm_background_pixel_update import gbu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_type,
   input  logic [PIX_W-1:0] req_pixel_index,
   input  logic [7:0]       req_chan_a,
   input  logic [7:0]       req_chan_b,
   input  logic [7:0]       req_chan_c,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_out_index,
   output logic             rsp_is_background,
   output logic [2:0]       rsp_component_total,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   gbu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gbu_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_type            (req_type),
      .req_pixel_index     (req_pixel_index),
      .req_chan_a          (req_chan_a),
      .req_chan_b          (req_chan_b),
      .req_chan_c          (req_chan_c),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_out_index       (rsp_out_index),
      .rsp_is_background   (rsp_is_background),
      .rsp_component_total (rsp_component_total)
   );

endmodule

/* tb/tb_gmm_background_pixel_update.sv */
// self-checking testbench for the gmm background pixel update block
module tb_gmm_background_pixel_update;
   import gbu_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = 12;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE = 200;
   localparam int STALL_LIMIT = 4000;

   typedef struct {
      longint means [SLOTS];
      longint sigma [SLOTS];
      longint weight [SLOTS];
      int     count;
   } pixel_model_type;

   typedef struct {
      logic [PIX_W-1:0] pix;
      logic             bg;
      logic [2:0]       total;
   } pixel_result_type;

   typedef struct {
      req_kind_type     kind;
      logic [PIX_W-1:0] pix;
      logic [7:0]       a, b, c;
      bit               typed;
      logic             bg;
      logic [2:0]       total;
   } stim_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic             req_type;
   logic [PIX_W-1:0] req_pixel_index;
   logic [7:0]       req_chan_a, req_chan_b, req_chan_c;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [PIX_W-1:0] rsp_out_index;
   logic             rsp_is_background;
   logic [2:0]       rsp_component_total;
   logic             csr_wr_en;
   logic [2:0]       csr_index;
   logic [15:0]      csr_data;

   gmm_background_pixel_update DUT (.*);

   // predictor copy of the registers and of the per-pixel models
   longint alpha, prior, init_sigma, fg_frac, floor_sigma, ceil_sigma, m_scale, b_scale;
   pixel_model_type models [int];
   pixel_result_type pending_results [$];

   int  errors = 0;
   int  quiet_cycles = 0;
   bit  idle_en = 1;
   bit  hold_long = 0;
   logic [PIX_W-1:0] pool [POOL];
   logic [7:0] palette [POOL][3][3];

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic longint adapt_mean(longint mu, longint x, longint rho);
      longint v;
      v = mu * 65536 + rho * (x - mu) + 32768;
      if (v < 0) v = 0;
      v = v >>> 16;
      if (v > 65535) v = 65535;
      return v;
   endfunction

   function automatic longint adapt_sigma(longint s, longint dist_sq, longint rho);
      longint s16, t, v;
      s16 = s << 8;
      t = s16 * 65536 + rho * (dist_sq - s16);
      v = 0;
      if (t > 0) v = (t + (longint'(1) << 23)) >>> 24;
      if (v > ceil_sigma) v = ceil_sigma;
      if (v < floor_sigma) v = floor_sigma;
      return v & 13'h1fff;
   endfunction

   function automatic pixel_result_type gmm_model_update(req_kind_type kind,
         logic [PIX_W-1:0] pix, logic [7:0] ca, logic [7:0] cb, logic [7:0] cc);
      pixel_result_type r;
      pixel_model_type  md;
      longint x [3];
      longint lm [SLOTS], ls [SLOTS], lw [SLOTS];
      longint packed_x, decay, sum, w, mu, s, t, rho, dist_sq, d, m, nm, tw, tm, ts;
      int n, j, touched;
      bit matched, hit;
      r.pix = pix;
      r.bg = 0;
      r.total = 0;
      sum = 0;
      j = 0;
      touched = -1;
      matched = 0;
      if (pix >= PIXEL_COUNT) return r;
      x[0] = longint'(ca) << 8;
      x[1] = longint'(cb) << 8;
      x[2] = longint'(cc) << 8;
      packed_x = x[0] | (x[1] << 16) | (x[2] << 32);
      if (kind == REQ_SEED) begin
         md.means[0] = packed_x;
         md.sigma[0] = init_sigma;
         md.weight[0] = 65536;
         md.count = 1;
         models[pix] = md;
         r.bg = 1;
         r.total = 1;
         return r;
      end
      md = models[pix];
      n = md.count;
      if (n > MAX_KEPT) n = MAX_KEPT;
      decay = alpha * prior;
      for (int i = 0; i < n; i++) begin
         w = md.weight[i] & 17'h1ffff;
         mu = md.means[i];
         s = md.sigma[i] & 13'h1fff;
         t = w * (65536 - alpha);
         rho = 65536;
         hit = 0;
         if (w != 0) begin
            rho = (alpha << 16) / w;
            if (rho > 65536) rho = 65536;
         end
         if (!matched) begin
            dist_sq = 0;
            for (int c = 0; c < 3; c++) begin
               m = (mu >> (16 * c)) & 16'hffff;
               d = x[c] > m ? x[c] - m : m - x[c];
               dist_sq += d * d;
            end
            if (sum < 65536 - fg_frac && dist_sq < b_scale * s * s) r.bg = 1;
            if (dist_sq < m_scale * s * s) begin
               matched = 1;
               hit = 1;
               t += alpha << 16;
               nm = 0;
               for (int c = 0; c < 3; c++)
                  nm |= adapt_mean((mu >> (16 * c)) & 16'hffff, x[c], rho) << (16 * c);
               mu = nm;
               s = adapt_sigma(s, dist_sq, rho);
            end
         end
         // pruned components vanish, a pruned match included
         if (t < 2 * decay) continue;
         lw[j] = (t - decay + 32768) >>> 16;
         lm[j] = mu;
         ls[j] = s;
         sum += lw[j];
         if (hit) touched = j;
         j++;
      end
      n = j;
      if (!matched) begin
         lw[n] = alpha;
         lm[n] = packed_x;
         ls[n] = init_sigma;
         sum += alpha;
         touched = n;
         n++;
      end
      if (sum > 0)
         for (int i = 0; i < n; i++) lw[i] = (lw[i] * 65536 + sum / 2) / sum;
      while (touched > 0 && lw[touched] > lw[touched-1]) begin
         tw = lw[touched]; tm = lm[touched]; ts = ls[touched];
         lw[touched] = lw[touched-1]; lm[touched] = lm[touched-1]; ls[touched] = ls[touched-1];
         lw[touched-1] = tw; lm[touched-1] = tm; ls[touched-1] = ts;
         touched--;
      end
      for (int i = 0; i < n; i++) begin
         md.means[i] = lm[i] & 48'hffffffffffff;
         md.sigma[i] = ls[i] & 13'h1fff;
         md.weight[i] = lw[i] & 17'h1ffff;
      end
      md.count = n;
      models[pix] = md;
      r.total = 3'(n);
      return r;
   endfunction

   task automatic send_item(req_kind_type kind, logic [PIX_W-1:0] pix,
         logic [7:0] ca, logic [7:0] cb, logic [7:0] cc, bit typed = 0,
         logic bg = 0, logic [2:0] total = 0);
      pixel_result_type r;
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= kind;
      req_pixel_index <= pix;
      req_chan_a <= ca;
      req_chan_b <= cb;
      req_chan_c <= cc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = gmm_model_update(kind, pix, ca, cb, cc);
      if (typed) begin
         r.bg = bg;
         r.total = total;
      end
      pending_results.push_back(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_data <= v;
      case (idx)
         CSR_LEARNING_RATE:       alpha = v;
         CSR_COMPLEXITY_PRIOR:    prior = v;
         CSR_INITIAL_SIGMA:       init_sigma = v & 13'h1fff;
         CSR_FOREGROUND_FRACTION: fg_frac = v;
         CSR_SIGMA_FLOOR:         floor_sigma = v & 13'h1fff;
         CSR_SIGMA_CEILING:       ceil_sigma = v & 13'h1fff;
         CSR_MATCH_SCALE:         m_scale = v & 5'h1f;
         CSR_BG_SCALE:            b_scale = v & 5'h1f;
         default: ;
      endcase
   endtask

   task automatic set_regs(int lr, int ct, int isg, int cf, int fl, int cl, int ms, int bs);
      write_reg(CSR_LEARNING_RATE, 16'(lr));
      write_reg(CSR_COMPLEXITY_PRIOR, 16'(ct));
      write_reg(CSR_INITIAL_SIGMA, 16'(isg));
      write_reg(CSR_FOREGROUND_FRACTION, 16'(cf));
      write_reg(CSR_SIGMA_FLOOR, 16'(fl));
      write_reg(CSR_SIGMA_CEILING, 16'(cl));
      write_reg(CSR_MATCH_SCALE, 16'(ms));
      write_reg(CSR_BG_SCALE, 16'(bs));
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic random_phase(int items, bit squeeze);
      int p, k, col;
      logic [7:0] ch [3];
      for (p = 0; p < POOL; p++)
         for (k = 0; k < 3; k++)
            for (col = 0; col < 3; col++) palette[p][k][col] = 8'($urandom);
      for (p = 0; p < POOL; p++)
         send_item(REQ_SEED, pool[p], palette[p][0][0], palette[p][0][1], palette[p][0][2]);
      for (int i = 0; i < items; i++) begin
         if (squeeze && i == items / 3) begin
            hold_long = 1;
            for (k = 0; k < 8; k++)
               send_item(REQ_UPDATE, pool[k], palette[k][0][0], palette[k][0][1],
                         palette[k][0][2]);
         end
         if (i == items / 2) drain();
         p = $urandom_range(0, POOL - 1);
         k = $urandom_range(0, 2);
         for (col = 0; col < 3; col++) begin
            // mostly samples near one of the pixel's colors, the rest noise
            if ($urandom_range(0, 4) == 0) ch[col] = 8'($urandom);
            else ch[col] = 8'(int'(palette[p][k][col]) + $urandom_range(0, 12) - 6);
         end
         send_item($urandom_range(0, 9) == 0 ? REQ_SEED : REQ_UPDATE, pool[p],
                   ch[0], ch[1], ch[2]);
      end
   endtask

   // receiver side stall
   initial begin
      int burst;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_stall <= 1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 0;
            rsp_stall <= 0;
         end else if (idle_en && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_stall <= 1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // result check against the oldest expected transaction
   always @(posedge clock) begin
      pixel_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result for pixel %0d", rsp_out_index);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_out_index !== e.pix) begin
               $error("out_index expected %0d actual %0d", e.pix, rsp_out_index);
               errors++;
            end
            if (rsp_is_background !== e.bg) begin
               $error("is_background expected %0d actual %0d", e.bg, rsp_is_background);
               errors++;
            end
            if (rsp_component_total !== e.total) begin
               $error("component_total expected %0d actual %0d", e.total,
                      rsp_component_total);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_gmm_background_pixel_update NOT OK");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [$];
      reset = 1;
      req_valid = 0;
      req_type = REQ_SEED;
      req_pixel_index = 0;
      req_chan_a = 0;
      req_chan_b = 0;
      req_chan_c = 0;
      csr_wr_en = 0;
      csr_index = CSR_LEARNING_RATE;
      csr_data = 0;
      alpha = 131; prior = 3277; init_sigma = 2816; fg_frac = 6554;
      floor_sigma = 1280; ceil_sigma = 5120; m_scale = 9; b_scale = 16;
      pool[0] = 0;
      pool[1] = 17'h1ffff;
      pool[2] = 17'h15555;
      pool[3] = 17'h0aaaa;
      for (int p = 4; p < POOL; p++) pool[p] = 17'($urandom);
      repeat (11) @(posedge clock);
      reset <= 0;

      rows = '{
         '{REQ_SEED,   17'd0,      8'd0,   8'd0,   8'd0,   1, 1, 3'd1},
         '{REQ_UPDATE, 17'd0,      8'd0,   8'd0,   8'd0,   0, 0, 3'd0},
         '{REQ_UPDATE, 17'd0,      8'd255, 8'd255, 8'd255, 0, 0, 3'd0},
         '{REQ_UPDATE, 17'd0,      8'd128, 8'd0,   8'd255, 0, 0, 3'd0},
         '{REQ_UPDATE, 17'd0,      8'd0,   8'd255, 8'd128, 0, 0, 3'd0},
         '{REQ_UPDATE, 17'd0,      8'd60,  8'd60,  8'd60,  0, 0, 3'd0},
         '{REQ_UPDATE, 17'd0,      8'd200, 8'd50,  8'd90,  0, 0, 3'd0},
         '{REQ_UPDATE, 17'd0,      8'd0,   8'd0,   8'd0,   0, 0, 3'd0},
         '{REQ_UPDATE, 17'd0,      8'd100, 8'd180, 8'd20,  0, 0, 3'd0},
         '{REQ_SEED,   17'h1ffff,  8'd255, 8'd255, 8'd255, 1, 1, 3'd1},
         '{REQ_UPDATE, 17'h1ffff,  8'd255, 8'd255, 8'd255, 0, 0, 3'd0},
         '{REQ_UPDATE, 17'h1ffff,  8'd254, 8'd255, 8'd253, 0, 0, 3'd0},
         '{REQ_UPDATE, 17'h1ffff,  8'd0,   8'd0,   8'd0,   0, 0, 3'd0},
         '{REQ_UPDATE, 17'h1ffff,  8'd0,   8'd0,   8'd0,   0, 0, 3'd0},
         '{REQ_SEED,   17'h15555,  8'd170, 8'd85,  8'd51,  1, 1, 3'd1},
         '{REQ_UPDATE, 17'h15555,  8'd171, 8'd84,  8'd52,  0, 0, 3'd0},
         '{REQ_SEED,   17'h0aaaa,  8'd85,  8'd170, 8'd204, 1, 1, 3'd1},
         '{REQ_UPDATE, 17'h0aaaa,  8'd85,  8'd170, 8'd204, 0, 0, 3'd0},
         '{REQ_SEED,   17'd0,      8'd1,   8'd2,   8'd3,   1, 1, 3'd1},
         '{REQ_UPDATE, 17'd0,      8'd1,   8'd2,   8'd3,   0, 0, 3'd0}
      };
      foreach (rows[i])
         send_item(rows[i].kind, rows[i].pix, rows[i].a, rows[i].b, rows[i].c,
                   rows[i].typed, rows[i].bg, rows[i].total);
      random_phase(300, 1);
      drain();

      // fast learning, heavy pruning, crossed clamps, widest thresholds
      set_regs(65535, 65535, 8191, 65535, 8191, 1, 31, 31);
      random_phase(250, 0);
      drain();
      // slowest learning, no decay, tightest thresholds
      set_regs(1, 0, 1, 0, 1, 8191, 1, 1);
      random_phase(250, 0);
      drain();
      set_regs(2000, 20000, 300, 30000, 100, 2000, 4, 20);
      random_phase(250, 1);
      drain();
      set_regs($urandom_range(1, 65535), $urandom_range(0, 65535), $urandom_range(1, 8191),
               $urandom_range(0, 65535), $urandom_range(1, 8191), $urandom_range(1, 8191),
               $urandom_range(1, 31), $urandom_range(1, 31));
      random_phase(300, 0);
      drain();
      set_regs(131, 3277, 2816, 6554, 1280, 5120, 9, 16);
      random_phase(300, 0);
      drain();
      idle_en = 0;
      set_regs(800, 8000, 1500, 10000, 600, 4000, 12, 25);
      random_phase(300, 0);
      drain();

      if (errors == 0)
         $display("tb_gmm_background_pixel_update OK");
      else
         $display("tb_gmm_background_pixel_update NOT OK");
      $finish;
   end

endmodule
